>>> sv/rsi_pkg.sv
// shared widths and constants for the ray/sphere intersection pipeline
package rsi_pkg;

  localparam int IN_W    = 320;  // input beat: nine coordinates and radius, byte padded
  localparam int OUT_W   = 40;   // output beat: distance, hit, saturated, byte padded
  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int V_W     = 33;   // origin - center
  localparam int A_W     = 64;   // dir.dir, unsigned
  localparam int B_W     = 66;   // v.dir, signed
  localparam int C_W     = 67;   // v.v - r^2, signed
  localparam int BM_W    = 65;   // |b|
  localparam int CM_W    = 66;   // |c|
  localparam int DISC_W  = 134;  // b^2 - a*c, signed
  localparam int X_W     = 133;  // non-negative discriminant into the root chain
  localparam int ROOT_W  = 67;   // floor square root of the discriminant
  localparam int NUM_W   = 69;   // -b - root, signed
  localparam int MAG_W   = 68;   // |num|
  localparam int MUL_DIGIT = 16; // multiplier digit per stage

endpackage

>>> sv/rsi_mul.sv
// pipelined unsigned multiplier, one 16-bit digit of b per stage
module rsi_mul #(
  parameter int AW = 65,
  parameter int BW = 65,
  parameter int TW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             vin,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  input  logic [TW-1:0]    tag_in,
  output logic             vout,
  output logic [AW+BW-1:0] p,
  output logic [TW-1:0]    tag_out
);
  import rsi_pkg::*;

  localparam int DW  = MUL_DIGIT;
  localparam int ND  = (BW + DW - 1) / DW;
  localparam int BPW = ND * DW;
  localparam int PW  = AW + BW;

  logic [AW-1:0]  a_r   [ND];
  logic [BPW-1:0] b_r   [ND];
  logic [PW-1:0]  acc_r [ND];
  logic [TW-1:0]  tag_r [ND];
  logic           v_r   [ND];

  for (genvar j = 0; j < ND; j++) begin : g_st
    logic [AW-1:0]    a_i;
    logic [BPW-1:0]   b_i;
    logic [PW-1:0]    acc_i;
    logic [TW-1:0]    t_i;
    logic             v_i;
    logic [AW+DW-1:0] pp;

    if (j == 0) begin : g_first
      assign a_i   = a;
      assign b_i   = BPW'(b);
      assign acc_i = '0;
      assign t_i   = tag_in;
      assign v_i   = vin;
    end else begin : g_next
      assign a_i   = a_r[j-1];
      assign b_i   = b_r[j-1];
      assign acc_i = acc_r[j-1];
      assign t_i   = tag_r[j-1];
      assign v_i   = v_r[j-1];
    end

    assign pp = {{DW{1'b0}}, a_i} * {{AW{1'b0}}, b_i[j*DW +: DW]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j] <= 1'b0;
      end else if (ce) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        a_r[j]   <= a_i;
        b_r[j]   <= b_i;
        tag_r[j] <= t_i;
        acc_r[j] <= acc_i + (PW'(pp) << (j * DW));
      end
    end
  end

  assign vout    = v_r[ND-1];
  assign p       = acc_r[ND-1];
  assign tag_out = tag_r[ND-1];

endmodule

>>> sv/rsi_sqrt_cell.sv
// one cell of the square root chain: settles root bit K
module rsi_sqrt_cell #(
  parameter int K  = 0,
  parameter int TW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        vin,
  input  logic [rsi_pkg::X_W-1:0]     rem_in,
  input  logic [rsi_pkg::ROOT_W-1:0]  root_in,
  input  logic [TW-1:0]               tag_in,
  output logic                        vout,
  output logic [rsi_pkg::X_W-1:0]     rem_out,
  output logic [rsi_pkg::ROOT_W-1:0]  root_out,
  output logic [TW-1:0]               tag_out
);
  import rsi_pkg::*;

  logic [X_W:0] trial;
  logic         ge;

  // (r + 2^K)^2 - r^2 = r * 2^(K+1) + 2^(2K), r has no bits at or below K
  assign trial = ((X_W+1)'(root_in) << (K + 1)) | ((X_W+1)'(1) << (2 * K));
  assign ge    = {1'b0, rem_in} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (ce) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_out  <= ge ? rem_in - trial[X_W-1:0] : rem_in;
      root_out <= ge ? (root_in | (ROOT_W'(1) << K)) : root_in;
      tag_out  <= tag_in;
    end
  end

endmodule

>>> sv/rsi_div_cell.sv
// one cell of the restoring divider chain: settles quotient bit K
module rsi_div_cell #(
  parameter int NW = 84,
  parameter int K  = 0,
  parameter int TW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  logic                   vin,
  input  logic [NW-1:0]          n_in,
  input  logic [rsi_pkg::A_W-1:0] d_in,
  input  logic [rsi_pkg::A_W-1:0] rem_in,
  input  logic [NW-1:0]          q_in,
  input  logic [TW-1:0]          tag_in,
  output logic                   vout,
  output logic [NW-1:0]          n_out,
  output logic [rsi_pkg::A_W-1:0] d_out,
  output logic [rsi_pkg::A_W-1:0] rem_out,
  output logic [NW-1:0]          q_out,
  output logic [TW-1:0]          tag_out
);
  import rsi_pkg::*;

  logic [A_W:0] r2;
  logic         ge;

  assign r2 = {rem_in, n_in[K]};
  assign ge = r2 >= {1'b0, d_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (ce) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n_out   <= n_in;
      d_out   <= d_in;
      rem_out <= ge ? A_W'(r2 - {1'b0, d_in}) : A_W'(r2);
      q_out   <= ge ? (q_in | (NW'(1) << K)) : q_in;
      tag_out <= tag_in;
    end
  end

endmodule

>>> sv/ray_sphere_intersect_core.sv
// ray/sphere intersection core: quadratic solve with root and divider cell chains
// Takes one ray and sphere per beat and returns the nearer root of the quadratic,
// signed fixed point with FRAC_BITS fraction bits, or -1.0 with hit low when the
// direction is zero or the discriminant is negative. A new ray is taken every
// cycle while s_tready is high. The path is four front stages, five multiplier
// digit stages, one discriminant stage, a chain of 67 square root cells (one
// root bit each), two stages forming the numerator and a chain of
// 68 + FRAC_BITS divider cells (one quotient bit each), then the output
// register. A two-entry output buffer lets the pipeline keep moving while
// a result waits; s_tready falls only when both entries are full.
module ray_sphere_intersect_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
  // center_z, radius, zero pad
  input  logic [rsi_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // distance, hit, saturated, zero pad
  output logic [rsi_pkg::OUT_W-1:0] m_tdata
);
  import rsi_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;
  localparam int SQ_TW = 1 + B_W + A_W;
  localparam logic [31:0] NEG_ONE = ~((32'd1 << FRAC_BITS) - 32'd1);
  localparam logic [31:0] POS_LIM = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIM = 32'h8000_0000;

  logic ce;

  // front stages
  logic signed [V_W-1:0]     v1  [3];
  logic signed [COORD_W-1:0] d1  [3];
  logic [RAD_W-1:0]          r1;
  logic                      val1;
  logic signed [63:0]        dd2 [3];
  logic signed [64:0]        vd2 [3];
  logic signed [65:0]        vv2 [3];
  logic [61:0]               rr2;
  logic                      val2;
  logic [A_W-1:0]            a3;
  logic signed [B_W-1:0]     b3;
  logic signed [C_W-1:0]     c3;
  logic                      val3;
  logic [BM_W-1:0]           bm4;
  logic [CM_W-1:0]           cm4;
  logic                      cn4;
  logic [A_W-1:0]            a4;
  logic [B_W-1:0]            b4;
  logic                      val4;

  always_ff @(posedge clk) begin
    if (rst) begin
      val1 <= 1'b0;
      val2 <= 1'b0;
      val3 <= 1'b0;
      val4 <= 1'b0;
    end else if (ce) begin
      val1 <= s_tvalid;
      val2 <= val1;
      val3 <= val2;
      val4 <= val3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        v1[i]  <= V_W'($signed(s_tdata[32*i +: 32])) - V_W'($signed(s_tdata[32*(6+i) +: 32]));
        d1[i]  <= $signed(s_tdata[32*(3+i) +: 32]);
        dd2[i] <= d1[i] * d1[i];
        vd2[i] <= v1[i] * d1[i];
        vv2[i] <= v1[i] * v1[i];
      end
      r1  <= s_tdata[288 +: RAD_W];
      rr2 <= r1 * r1;
      a3  <= $unsigned(dd2[0]) + $unsigned(dd2[1]) + $unsigned(dd2[2]);
      b3  <= B_W'(vd2[0]) + B_W'(vd2[1]) + B_W'(vd2[2]);
      c3  <= C_W'(vv2[0]) + C_W'(vv2[1]) + C_W'(vv2[2]) - $signed({5'b0, rr2});
      bm4 <= BM_W'(b3[B_W-1] ? -b3 : b3);
      cm4 <= CM_W'(c3[C_W-1] ? -c3 : c3);
      cn4 <= c3[C_W-1];
      a4  <= a3;
      b4  <= b3;
    end
  end

  // b^2 and a*|c|
  logic                  vm;
  logic [2*BM_W-1:0]     bb;
  logic [SQ_TW-2:0]      ab_m;
  logic [CM_W+BM_W-1:0]  ac;
  logic                  cn_m;

  rsi_mul #(.AW(BM_W), .BW(BM_W), .TW(A_W + B_W)) u_mul_bb (
    .clk, .rst, .ce, .vin(val4), .a(bm4), .b(bm4), .tag_in({b4, a4}),
    .vout(vm), .p(bb), .tag_out(ab_m)
  );

  rsi_mul #(.AW(CM_W), .BW(BM_W), .TW(1)) u_mul_ac (
    .clk, .rst, .ce, .vin(val4), .a(cm4), .b({1'b0, a4}), .tag_in(cn4),
    .vout(), .p(ac), .tag_out(cn_m)
  );

  // discriminant, then into the root chain
  logic [DISC_W-1:0] disc;
  logic              nh_d;
  logic [X_W-1:0]    x5;
  logic [SQ_TW-1:0]  t5;
  logic              val5;

  assign disc = cn_m ? {4'b0, bb} + {3'b0, ac} : {4'b0, bb} - {3'b0, ac};
  assign nh_d = (ab_m[A_W-1:0] == '0) || disc[DISC_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      val5 <= 1'b0;
    end else if (ce) begin
      val5 <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x5 <= nh_d ? '0 : disc[X_W-1:0];
      t5 <= {nh_d, ab_m};
    end
  end

  logic [X_W-1:0]    sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [SQ_TW-1:0]  sq_tag  [ROOT_W+1];
  logic              sq_v    [ROOT_W+1];

  assign sq_rem[0]  = x5;
  assign sq_root[0] = '0;
  assign sq_tag[0]  = t5;
  assign sq_v[0]    = val5;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    rsi_sqrt_cell #(.K(ROOT_W - 1 - i), .TW(SQ_TW)) u_cell (
      .clk, .rst, .ce, .vin(sq_v[i]), .rem_in(sq_rem[i]), .root_in(sq_root[i]),
      .tag_in(sq_tag[i]), .vout(sq_v[i+1]), .rem_out(sq_rem[i+1]),
      .root_out(sq_root[i+1]), .tag_out(sq_tag[i+1])
    );
  end

  // numerator -b - root, then its magnitude scaled by the fraction bits
  logic signed [NUM_W-1:0] n6;
  logic [A_W-1:0]          a6;
  logic                    nh6;
  logic                    val6;
  logic [MAG_W-1:0]        mag7;
  logic [A_W-1:0]          a7;
  logic                    nh7;
  logic                    neg7;
  logic                    val7;

  always_ff @(posedge clk) begin
    if (rst) begin
      val6 <= 1'b0;
      val7 <= 1'b0;
    end else if (ce) begin
      val6 <= sq_v[ROOT_W];
      val7 <= val6;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n6   <= -NUM_W'($signed(sq_tag[ROOT_W][A_W +: B_W]))
              - $signed({2'b0, sq_root[ROOT_W]});
      a6   <= sq_tag[ROOT_W][A_W-1:0];
      nh6  <= sq_tag[ROOT_W][SQ_TW-1];
      mag7 <= MAG_W'(n6[NUM_W-1] ? -n6 : n6);
      neg7 <= n6[NUM_W-1];
      a7   <= a6;
      nh7  <= nh6;
    end
  end

  logic [NW-1:0]  dv_n   [NW+1];
  logic [A_W-1:0] dv_d   [NW+1];
  logic [A_W-1:0] dv_rem [NW+1];
  logic [NW-1:0]  dv_q   [NW+1];
  logic [1:0]     dv_tag [NW+1];
  logic           dv_v   [NW+1];

  assign dv_n[0]   = {mag7, {FRAC_BITS{1'b0}}};
  assign dv_d[0]   = a7;
  assign dv_rem[0] = '0;
  assign dv_q[0]   = '0;
  assign dv_tag[0] = {nh7, neg7};
  assign dv_v[0]   = val7;

  for (genvar i = 0; i < NW; i++) begin : g_div
    rsi_div_cell #(.NW(NW), .K(NW - 1 - i), .TW(2)) u_cell (
      .clk, .rst, .ce, .vin(dv_v[i]), .n_in(dv_n[i]), .d_in(dv_d[i]),
      .rem_in(dv_rem[i]), .q_in(dv_q[i]), .tag_in(dv_tag[i]),
      .vout(dv_v[i+1]), .n_out(dv_n[i+1]), .d_out(dv_d[i+1]),
      .rem_out(dv_rem[i+1]), .q_out(dv_q[i+1]), .tag_out(dv_tag[i+1])
    );
  end

  // clamp, sign and no-hit override
  logic [NW-1:0] q;
  logic          neg_f;
  logic          nh_f;
  logic [31:0]   lim;
  logic          sat_f;
  logic [31:0]   mag_f;
  logic [33:0]   res;

  assign q     = dv_q[NW];
  assign neg_f = dv_tag[NW][0];
  assign nh_f  = dv_tag[NW][1];
  assign lim   = neg_f ? NEG_LIM : POS_LIM;
  assign sat_f = (q[NW-1:32] != '0) || (q[31:0] > lim);
  assign mag_f = sat_f ? lim : q[31:0];

  always_comb begin
    if (nh_f) begin
      res = {1'b0, 1'b0, NEG_ONE};
    end else begin
      res = {sat_f, 1'b1, neg_f ? -mag_f : mag_f};
    end
  end

  // output register with skid entry
  logic        out_valid;
  logic [33:0] out_data;
  logic        skid_valid;
  logic [33:0] skid_data;
  logic        take;
  logic        incoming;

  assign ce       = !skid_valid;
  assign s_tready = ce;
  assign take     = out_valid && m_tready;
  assign incoming = ce && dv_v[NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid || take) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_data};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without output entry");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data[32]) |-> (out_data[31:0] == NEG_ONE && !out_data[33]))
    else $error("miss beat without -1.0 distance");

  a_sat_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[33]) |-> out_data[32])
    else $error("saturated set on a miss");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> skid_valid)
    else $error("skid entry lost while stalled");

endmodule
